// ===== design/balloc_pkg.sv =====
// ----------------------------------------------------------------------------
// balloc_pkg
// Shared types and codes of the bump allocator: field widths, opcodes,
// status codes, register indexes and the table record layout.
// ----------------------------------------------------------------------------
package balloc_pkg;

   localparam int TABLE_DEPTH_DEF = 512;
   localparam int OFFSET_BITS_DEF = 30;

   localparam int OFF_W    = 30;
   localparam int SIZE_W   = 31;
   localparam int STATUS_W = 3;
   localparam int OP_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [OFF_W-1:0] START_RESET = OFF_W'(40960);
   localparam logic [SIZE_W-1:0] REGION_RESET = SIZE_W'(1073741824);

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOC_LOCKED = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_LOCKED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
   localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd6;
   localparam logic [STATUS_W-1:0] ST_NULL      = 3'd7;

   typedef struct packed {
      logic [OFF_W-1:0]  offset;
      logic [SIZE_W-1:0] size;
      logic              in_use;
      logic              reused;
   } record_type;

   localparam int RECORD_W = $bits(record_type);

endpackage

// ===== design/balloc_req_if.sv =====
// ----------------------------------------------------------------------------
// balloc_req_if
// Request channel of the allocator: opcode, byte count and block offset.
// ----------------------------------------------------------------------------
interface balloc_req_if;
   logic                                valid;
   logic                                ready;
   logic [balloc_pkg::OP_W-1:0]         opcode;
   logic [balloc_pkg::SIZE_W-1:0]       byte_count;
   logic [balloc_pkg::OFF_W-1:0]        block_offset;

   modport source (output valid, opcode, byte_count, block_offset, input ready);
   modport sink   (input valid, opcode, byte_count, block_offset, output ready);
endinterface

// ===== design/balloc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// balloc_rsp_if
// Response channel of the allocator: status, granted block and running totals.
// ----------------------------------------------------------------------------
interface balloc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [balloc_pkg::STATUS_W-1:0]     status;
   logic [balloc_pkg::OFF_W-1:0]        result_offset;
   logic [balloc_pkg::SIZE_W-1:0]       result_size;
   logic [balloc_pkg::SIZE_W-1:0]       bytes_allocated;
   logic [balloc_pkg::SIZE_W-1:0]       bytes_released;

   modport source (output valid, status, result_offset, result_size,
                   bytes_allocated, bytes_released, input ready);
   modport sink   (input valid, status, result_offset, result_size,
                   bytes_allocated, bytes_released, output ready);
endinterface

// ===== design/balloc_ram.sv =====
// ----------------------------------------------------------------------------
// balloc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module balloc_ram #(
   parameter int WIDTH = balloc_pkg::RECORD_W,
   parameter int DEPTH = balloc_pkg::TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bump_allocator_with_size_reuse_unit.sv =====
// ----------------------------------------------------------------------------
// bump_allocator_with_size_reuse_unit
// Bump allocator over a byte region with a record table and exact-size reuse.
// ----------------------------------------------------------------------------
// One item is worked at a time. Items that need no table lookup (locked or
// zero-size allocate, null release or query, unused opcode, or an empty
// table) go from accept straight to the finish state. An allocate, release
// or query otherwise walks the record table in order, one record per cycle
// from the single read port of the table RAM, and stops at the first match
// or after the last record. The finish state waits until the output
// register can take the result. A result sits in an output register; the
// next item is accepted while it waits. The table needs no clearing after
// reset: only records below the record count are ever used.
module bump_allocator_with_size_reuse_unit #(
   parameter int TABLE_DEPTH = balloc_pkg::TABLE_DEPTH_DEF,
   parameter int OFFSET_BITS = balloc_pkg::OFFSET_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [balloc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [balloc_pkg::CSR_DATA_W-1:0] csr_wdata,
   balloc_req_if.sink                        req_ch,
   balloc_rsp_if.source                      rsp_ch
);

   import balloc_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [63:0] CAP64 = 64'd1 << OFFSET_BITS;
   localparam logic [31:0] CAP = (CAP64 > 64'h8000_0000) ? 32'h8000_0000 : CAP64[31:0];
   localparam logic [OFF_W-1:0] OFF_MASK =
      (OFFSET_BITS >= OFF_W) ? {OFF_W{1'b1}} : OFF_W'(CAP64 - 64'd1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0] region_size_ff;
   logic              locked_ff;
   logic [CNT_W-1:0]  record_count_ff;
   logic [OFF_W-1:0]  bump_ptr_ff;
   logic [SIZE_W-1:0] alloc_total_ff;
   logic [SIZE_W-1:0] rel_total_ff;

   logic [OP_W-1:0]   op_ff;
   logic [SIZE_W-1:0] count_ff;
   logic [OFF_W-1:0]  off_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   record_type        hit_rec_ff;
   logic [IDX_W-1:0]  rd_idx_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [OFF_W-1:0]    rsp_off_ff;
   logic [SIZE_W-1:0]   rsp_size_ff;
   logic [SIZE_W-1:0]   rsp_alloc_ff;
   logic [SIZE_W-1:0]   rsp_rel_ff;

   logic [IDX_W-1:0] rd_addr;
   record_type       rd_data;

   logic             req_fire;
   logic [OFF_W-1:0] in_off;
   logic             in_scan;
   logic             scan_hit;
   logic             scan_last;
   logic             commit;

   logic [STATUS_W-1:0] dec_status;
   logic [OFF_W-1:0]    dec_off;
   logic [SIZE_W-1:0]   dec_size;
   logic                dec_we;
   logic [IDX_W-1:0]    dec_addr;
   record_type          dec_rec;
   logic                dec_append;
   logic                dec_release;

   logic [OFF_W-1:0]    base;
   logic [31:0]         base_sum;
   logic [31:0]         limit;
   logic                over;
   logic [31:0]         rel_sum;
   logic [SIZE_W-1:0]   rel_next;
   logic [SIZE_W-1:0]   alloc_next;
   logic [OFF_W-1:0]    start_load;

   // ---------------------------------------------------------------- table
   balloc_ram #(
      .WIDTH (RECORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (dec_we && commit),
      .wr_addr (dec_addr),
      .wr_data (dec_rec),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------ accept/scan
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_off       = req_ch.block_offset & OFF_MASK;

   always_comb begin
      in_scan = 1'b0;
      if (record_count_ff != '0) begin
         if (req_ch.opcode == OP_ALLOC) begin
            in_scan = !locked_ff && (req_ch.byte_count != '0);
         end else if (req_ch.opcode == OP_RELEASE || req_ch.opcode == OP_QUERY) begin
            in_scan = (in_off != '0);
         end
      end
   end

   // issue the next record each cycle; data for rd_idx_ff arrives now
   assign rd_addr = (state_ff == S_SCAN) ? rd_idx_ff + IDX_W'(1) : '0;

   assign scan_hit  = (op_ff == OP_ALLOC) ? (!rd_data.in_use && rd_data.size == count_ff)
                                          : (rd_data.offset == off_ff);
   assign scan_last = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == record_count_ff;

   assign commit = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = in_scan ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- decide
   assign limit    = ({1'b0, region_size_ff} < CAP) ? {1'b0, region_size_ff} : CAP;
   assign base     = found_ff ? hit_rec_ff.offset : bump_ptr_ff;
   assign base_sum = {2'b00, base} + {1'b0, count_ff};
   assign over     = (base_sum >= limit);

   assign rel_sum    = {1'b0, rel_total_ff} + {1'b0, hit_rec_ff.size};
   assign rel_next   = rel_sum[31] ? {SIZE_W{1'b1}} : rel_sum[SIZE_W-1:0];
   assign alloc_next = alloc_total_ff + count_ff;

   always_comb begin
      dec_status  = ST_OK;
      dec_off     = '0;
      dec_size    = '0;
      dec_we      = 1'b0;
      dec_addr    = hit_idx_ff;
      dec_rec     = hit_rec_ff;
      dec_append  = 1'b0;
      dec_release = 1'b0;
      unique case (op_ff)
         OP_ALLOC: begin
            if (locked_ff) begin
               dec_status = ST_LOCKED;
            end else if (count_ff == '0) begin
               dec_status = ST_ZERO;
            end else if (found_ff) begin
               if (over) begin
                  dec_status = ST_OVERFLOW;
               end else begin
                  dec_we         = 1'b1;
                  dec_rec.in_use = 1'b1;
                  dec_rec.reused = 1'b1;
                  dec_off        = hit_rec_ff.offset;
                  dec_size       = count_ff;
               end
            end else if (record_count_ff >= CNT_W'(TABLE_DEPTH)) begin
               dec_status = ST_FULL;
            end else if (over) begin
               dec_status = ST_OVERFLOW;
            end else begin
               dec_we         = 1'b1;
               dec_append     = 1'b1;
               dec_addr       = record_count_ff[IDX_W-1:0];
               dec_rec.offset = bump_ptr_ff;
               dec_rec.size   = count_ff;
               dec_rec.in_use = 1'b1;
               dec_rec.reused = 1'b0;
               dec_off        = bump_ptr_ff;
               dec_size       = count_ff;
            end
         end
         OP_RELEASE: begin
            if (off_ff != '0) begin
               if (!found_ff) begin
                  dec_status = ST_NOT_FOUND;
               end else if (!hit_rec_ff.in_use) begin
                  dec_status = ST_DOUBLE;
               end else begin
                  dec_we         = 1'b1;
                  dec_rec.in_use = 1'b0;
                  dec_release    = !hit_rec_ff.reused;
               end
            end
         end
         OP_QUERY: begin
            if (off_ff == '0) begin
               dec_status = ST_NULL;
            end else if (!found_ff) begin
               dec_status = ST_NOT_FOUND;
            end else begin
               dec_size = hit_rec_ff.size;
            end
         end
         default: ;
      endcase
   end

   // a zero start offset would put a grant at the null offset
   assign start_load = (csr_wdata[OFF_W-1:0] == '0) ? OFF_W'(1) : csr_wdata[OFF_W-1:0];

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         region_size_ff  <= REGION_RESET;
         locked_ff       <= 1'b0;
         record_count_ff <= '0;
         bump_ptr_ff     <= START_RESET;
         alloc_total_ff  <= SIZE_W'(START_RESET);
         rel_total_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (commit && dec_append) begin
            record_count_ff <= record_count_ff + CNT_W'(1);
            bump_ptr_ff     <= base_sum[OFF_W-1:0];
            alloc_total_ff  <= alloc_next;
         end
         if (commit && dec_release) begin
            rel_total_ff <= rel_next;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_REGION_SIZE: region_size_ff <= csr_wdata;
               CSR_START_OFFSET: begin
                  if (record_count_ff == '0) begin
                     bump_ptr_ff    <= start_load;
                     alloc_total_ff <= SIZE_W'(start_load);
                  end
               end
               CSR_ALLOC_LOCKED: locked_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_ch.opcode;
         count_ff  <= req_ch.byte_count;
         off_ff    <= in_off;
         found_ff  <= 1'b0;
         rd_idx_ff <= '0;
      end else if (state_ff == S_SCAN) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
         if (scan_hit) begin
            found_ff   <= 1'b1;
            hit_idx_ff <= rd_idx_ff;
            hit_rec_ff <= rd_data;
         end
      end
      if (commit) begin
         rsp_status_ff <= dec_status;
         rsp_off_ff    <= dec_off;
         rsp_size_ff   <= dec_size;
         rsp_alloc_ff  <= dec_append ? alloc_next : alloc_total_ff;
         rsp_rel_ff    <= dec_release ? rel_next : rel_total_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.result_offset   = rsp_off_ff;
   assign rsp_ch.result_size     = rsp_size_ff;
   assign rsp_ch.bytes_allocated = rsp_alloc_ff;
   assign rsp_ch.bytes_released  = rsp_rel_ff;

   // ------------------------------------------------------------ assertions
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (CNT_W'(rd_idx_ff) < record_count_ff))
      else $error("table walk beyond record count");

   a_hit_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && found_ff) |-> (CNT_W'(hit_idx_ff) < record_count_ff))
      else $error("matched record outside table");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      record_count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("record count exceeds table depth");

   a_commit_frees: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished item not presented");

endmodule
